// ===== rtl/rbps_pkg.sv =====
// Shared constants and item type for the radial binned pixel statistics block.
`default_nettype none

package rbps_pkg;

    localparam int BINS       = 16;
    localparam int BIN_W      = $clog2(BINS);
    localparam int BIN_OUT_W  = 4;
    localparam int SEL_W      = 4;
    localparam int POS_W      = 14;
    localparam int PIX_W      = 32;
    localparam int COUNT_W    = 28;
    localparam int SUM_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int CENTER_W   = 24;
    localparam int RADIUS_W   = 48;
    localparam int SCALE_W    = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [PIX_W-1:0]   MIN_RESET = {PIX_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS_SQ = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE     = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [BIN_W-1:0] bin;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/rbps_front.sv =====
// Front end: configuration registers and pipelined radial bin classification.
`default_nettype none

module rbps_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [rbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [rbps_pkg::POS_W-1:0]     s_row,
    input  wire logic [rbps_pkg::POS_W-1:0]     s_col,
    input  wire logic [rbps_pkg::PIX_W-1:0]     s_pixel,
    input  wire logic [rbps_pkg::SEL_W-1:0]     s_bin_select,
    output logic                                push,
    output rbps_pkg::item_t                     push_item,
    input  wire logic                           fifo_full
);
    import rbps_pkg::*;

    localparam int DIFF_W = CENTER_W + 2;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int HI_W   = DIST_W - 32;
    localparam int PLO_W  = 32 + SCALE_W;
    localparam int PHI_W  = HI_W + SCALE_W;
    localparam int ACC_W  = PHI_W + 1;
    localparam int IDX_W  = ACC_W - 16;

    logic signed [CENTER_W-1:0] center_x_reg;
    logic signed [CENTER_W-1:0] center_y_reg;
    logic [RADIUS_W-1:0]        min_radius_sq_reg;
    logic [SCALE_W-1:0]         bin_scale_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    item_t it1_reg, it2_reg, it3_reg, it4_reg;
    logic [MAG_W-1:0]  mag_x_reg, mag_y_reg;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg;
    logic [DIST_W-1:0] diff_reg;
    logic              inner3_reg, inner4_reg;
    logic [PLO_W-1:0]  plo_reg;
    logic [PHI_W-1:0]  phi_reg;

    logic                     advance;
    logic signed [DIFF_W-1:0] dx, dy, dx_neg, dy_neg;
    logic [MAG_W-1:0]         mag_x, mag_y;
    logic [BIN_W-1:0]         sel_bin;
    logic [DIST_W-1:0]        dist2;
    logic [ACC_W-1:0]         acc;
    logic [IDX_W-1:0]         idx;
    logic [BIN_W-1:0]         radial_bin;
    item_t                    in_item;

    assign advance = !v4_reg || !fifo_full;
    assign s_ready = advance;
    assign push    = v4_reg && !fifo_full;

    always_comb begin
        dx      = $signed({{(DIFF_W-POS_W-8){1'b0}}, s_col, 8'b0}) - DIFF_W'(center_x_reg);
        dy      = $signed({{(DIFF_W-POS_W-8){1'b0}}, s_row, 8'b0}) - DIFF_W'(center_y_reg);
        dx_neg  = -dx;
        dy_neg  = -dy;
        mag_x   = dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
        mag_y   = dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
        sel_bin = (int'(s_bin_select) >= BINS) ? BIN_W'(BINS - 1) : BIN_W'(s_bin_select);
        in_item = '{kind: s_kind, bin: sel_bin, row: s_row, col: s_col, pixel: s_pixel};
        dist2   = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg);
        acc     = ACC_W'(phi_reg) + ACC_W'(plo_reg[PLO_W-1:32]);
        idx     = acc[ACC_W-1:16];
        if (inner4_reg) begin
            radial_bin = '0;
        end else if (idx >= IDX_W'(BINS)) begin
            radial_bin = BIN_W'(BINS - 1);
        end else begin
            radial_bin = idx[BIN_W-1:0];
        end
        push_item = it4_reg;
        if (it4_reg.kind == KIND_ACCUM) begin
            push_item.bin = radial_bin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            min_radius_sq_reg <= '0;
            bin_scale_reg     <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CENTER_X:      center_x_reg      <= cfg_wdata[CENTER_W-1:0];
                    CFG_CENTER_Y:      center_y_reg      <= cfg_wdata[CENTER_W-1:0];
                    CFG_MIN_RADIUS_SQ: min_radius_sq_reg <= cfg_wdata[RADIUS_W-1:0];
                    CFG_BIN_SCALE:     bin_scale_reg     <= cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (advance) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            it1_reg    <= in_item;
            mag_x_reg  <= mag_x;
            mag_y_reg  <= mag_y;
            it2_reg    <= it1_reg;
            sq_x_reg   <= mag_x_reg * mag_x_reg;
            sq_y_reg   <= mag_y_reg * mag_y_reg;
            it3_reg    <= it2_reg;
            inner3_reg <= dist2 <= DIST_W'(min_radius_sq_reg);
            diff_reg   <= dist2 - DIST_W'(min_radius_sq_reg);
            it4_reg    <= it3_reg;
            inner4_reg <= inner3_reg;
            plo_reg    <= diff_reg[31:0] * bin_scale_reg;
            phi_reg    <= diff_reg[DIST_W-1:32] * bin_scale_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rbps_fifo.sv =====
// Short item queue between the classification front end and the bin update back end.
`default_nettype none

module rbps_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rbps_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output rbps_pkg::item_t      pop_item,
    output logic                 empty
);
    import rbps_pkg::*;

    item_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full     = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rbps_back.sv =====
// Back end: per-bin statistics storage with read-modify-write update and result register.
`default_nettype none

module rbps_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rbps_pkg::item_t              pop_item,
    input  wire logic                         empty,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rbps_pkg::BIN_OUT_W-1:0]    m_bin,
    output logic [rbps_pkg::COUNT_W-1:0]      m_count,
    output logic [rbps_pkg::SUM_W-1:0]        m_sum,
    output logic [rbps_pkg::SUM_W-1:0]        m_sum_sq,
    output logic [rbps_pkg::PIX_W-1:0]        m_min_value,
    output logic [rbps_pkg::POS_W-1:0]        m_min_row,
    output logic [rbps_pkg::POS_W-1:0]        m_min_col,
    output logic [rbps_pkg::PIX_W-1:0]        m_max_value,
    output logic [rbps_pkg::POS_W-1:0]        m_max_row,
    output logic [rbps_pkg::POS_W-1:0]        m_max_col
);
    import rbps_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   sum_sq;
        logic [PIX_W-1:0]   min_v;
        logic [POS_W-1:0]   min_row;
        logic [POS_W-1:0]   min_col;
        logic [PIX_W-1:0]   max_v;
        logic [POS_W-1:0]   max_row;
        logic [POS_W-1:0]   max_col;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    localparam entry_t ENTRY_RESET = '{count: '0, sum: '0, sum_sq: '0, min_v: MIN_RESET,
                                       min_row: '0, min_col: '0, max_v: '0,
                                       max_row: '0, max_col: '0};

    state_t               state_reg;
    entry_t               bins_reg [BINS];
    item_t                item_reg;
    entry_t               ent_reg;
    logic [SUM_W-1:0]     sq_reg;
    logic                 m_valid_reg;
    logic [BIN_W-1:0]     m_bin_reg;
    entry_t               out_reg;

    entry_t               ent_next;
    logic [SUM_W:0]       sum_sq_wide;
    logic                 load_out;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign load_out = (state_reg == ST_WRITE) && (!m_valid_reg || m_ready);

    always_comb begin
        ent_next    = ent_reg;
        sum_sq_wide = {1'b0, ent_reg.sum_sq} + {1'b0, sq_reg};
        if (item_reg.kind == KIND_ACCUM) begin
            if (ent_reg.count != COUNT_MAX) begin
                ent_next.count = ent_reg.count + 1'b1;
            end
            ent_next.sum    = ent_reg.sum + SUM_W'(item_reg.pixel);
            ent_next.sum_sq = sum_sq_wide[SUM_W] ? {SUM_W{1'b1}} : sum_sq_wide[SUM_W-1:0];
            if (item_reg.pixel < ent_reg.min_v) begin
                ent_next.min_v   = item_reg.pixel;
                ent_next.min_row = item_reg.row;
                ent_next.min_col = item_reg.col;
            end
            if (item_reg.pixel > ent_reg.max_v) begin
                ent_next.max_v   = item_reg.pixel;
                ent_next.max_row = item_reg.row;
                ent_next.max_col = item_reg.col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < BINS; i++) begin
                bins_reg[i] <= ENTRY_RESET;
            end
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        item_reg  <= pop_item;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    ent_reg   <= bins_reg[item_reg.bin];
                    sq_reg    <= item_reg.pixel * item_reg.pixel;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (load_out) begin
                        if (item_reg.kind == KIND_ACCUM) begin
                            bins_reg[item_reg.bin] <= ent_next;
                        end
                        out_reg     <= ent_next;
                        m_bin_reg   <= item_reg.bin;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin       = BIN_OUT_W'(m_bin_reg);
    assign m_count     = out_reg.count;
    assign m_sum       = out_reg.sum;
    assign m_sum_sq    = out_reg.sum_sq;
    assign m_min_value = out_reg.min_v;
    assign m_min_row   = out_reg.min_row;
    assign m_min_col   = out_reg.min_col;
    assign m_max_value = out_reg.max_v;
    assign m_max_row   = out_reg.max_row;
    assign m_max_col   = out_reg.max_col;

endmodule

`default_nettype wire

// ===== rtl/radial_bin_pixel_statistics.sv =====
// An accepted item passes the 4-stage front end, the 4-deep queue and the bin
// read-modify-write sequence (pop, read entry and square pixel, write entry) before
// its result is valid. That sequence handles one item at a time and waits in its
// write step while a result is stalled; the front end and queue let items be
// accepted ahead of the back end. Reset: synchronous, aresetn low clears
// configuration, queue and all bins (count, sums, maximum to zero, minimum to all ones).
// Top level of the radial binned pixel statistics block.
`default_nettype none

module radial_bin_pixel_statistics (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [rbps_pkg::POS_W-1:0]      s_row,
    input  wire logic [rbps_pkg::POS_W-1:0]      s_col,
    input  wire logic [rbps_pkg::PIX_W-1:0]      s_pixel,
    input  wire logic [rbps_pkg::SEL_W-1:0]      s_bin_select,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rbps_pkg::BIN_OUT_W-1:0]       m_bin,
    output logic [rbps_pkg::COUNT_W-1:0]         m_count,
    output logic [rbps_pkg::SUM_W-1:0]           m_sum,
    output logic [rbps_pkg::SUM_W-1:0]           m_sum_sq,
    output logic [rbps_pkg::PIX_W-1:0]           m_min_value,
    output logic [rbps_pkg::POS_W-1:0]           m_min_row,
    output logic [rbps_pkg::POS_W-1:0]           m_min_col,
    output logic [rbps_pkg::PIX_W-1:0]           m_max_value,
    output logic [rbps_pkg::POS_W-1:0]           m_max_row,
    output logic [rbps_pkg::POS_W-1:0]           m_max_col
);
    import rbps_pkg::*;

    logic  push, pop, fifo_full, fifo_empty;
    item_t push_item, pop_item;

    rbps_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_pixel      (s_pixel),
        .s_bin_select (s_bin_select),
        .push         (push),
        .push_item    (push_item),
        .fifo_full    (fifo_full)
    );

    rbps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    rbps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_item    (pop_item),
        .empty       (fifo_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin       (m_bin),
        .m_count     (m_count),
        .m_sum       (m_sum),
        .m_sum_sq    (m_sum_sq),
        .m_min_value (m_min_value),
        .m_min_row   (m_min_row),
        .m_min_col   (m_min_col),
        .m_max_value (m_max_value),
        .m_max_row   (m_max_row),
        .m_max_col   (m_max_col)
    );

endmodule

`default_nettype wire

// ===== rtl/rbps_checker.sv =====
// Port-level assertion checker for the radial binned pixel statistics block, with its bind.
`default_nettype none

module rbps_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [rbps_pkg::BIN_OUT_W-1:0] m_bin,
    input wire logic [rbps_pkg::COUNT_W-1:0] m_count,
    input wire logic [rbps_pkg::SUM_W-1:0]   m_sum,
    input wire logic [rbps_pkg::SUM_W-1:0]   m_sum_sq,
    input wire logic [rbps_pkg::PIX_W-1:0]   m_min_value,
    input wire logic [rbps_pkg::PIX_W-1:0]   m_max_value
);
    import rbps_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin) && $stable(m_count)
            && $stable(m_sum) && $stable(m_sum_sq))
        else $error("stalled result changed");

    a_empty_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count == '0 |-> m_sum == '0 && m_sum_sq == '0
            && m_min_value == MIN_RESET && m_max_value == '0)
        else $error("empty bin not at reset values");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count != '0 |-> m_min_value <= m_max_value)
        else $error("bin minimum above maximum");

    a_single_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count == COUNT_W'(1) |-> m_sum == SUM_W'(m_max_value))
        else $error("single-pixel bin sum mismatch");

endmodule

bind radial_bin_pixel_statistics rbps_checker u_rbps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin       (m_bin),
    .m_count     (m_count),
    .m_sum       (m_sum),
    .m_sum_sq    (m_sum_sq),
    .m_min_value (m_min_value),
    .m_max_value (m_max_value)
);

`default_nettype wire
